// ----- design/msrf_pkg.sv -----
// ---------------------------------------------------------------------------
// msrf_pkg: shared types and constants for the message slot ring FIFO
// Ring geometry, status and command codes, controller/datapath interface.
// ---------------------------------------------------------------------------
package msrf_pkg;

  localparam int unsigned RING_SLOTS = 16;  // 2 .. 1024
  localparam int unsigned SLOT_BYTES = 64;  // 1 .. 64

  localparam int unsigned SLOT_IDX_W = $clog2(RING_SLOTS);
  localparam int unsigned BYTE_IDX_W = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
  localparam int unsigned LEN_W      = $clog2(SLOT_BYTES + 1);
  localparam int unsigned STORE_DEPTH = RING_SLOTS * (2 ** BYTE_IDX_W);
  localparam int unsigned STORE_AW    = SLOT_IDX_W + BYTE_IDX_W;
  localparam int unsigned CNT_W       = 64;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
  typedef logic [BYTE_IDX_W-1:0] byte_idx_t;
  typedef logic [LEN_W-1:0]      len_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_POP   = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    STAT_ACCEPT = 3'd0,
    STAT_FULL   = 3'd1,
    STAT_LONG   = 3'd2,
    STAT_BYTE   = 3'd3,
    STAT_EMPTY  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RJ_NONE = 2'd0,
    RJ_LONG = 2'd2
  } reject_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_STREAM = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic wr_byte;    // accepted write byte
    logic pop_start;  // accepted pop of a queued message
    logic pop_empty;  // accepted pop with nothing queued
    logic emit_byte;  // move the current stored byte to the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;      // no message at the read slot
    logic last_byte;  // current stream byte is the final one
    logic out_free;   // output register can load this cycle
  } dp_status_t;

  function automatic slot_idx_t next_slot(input slot_idx_t idx);
    slot_idx_t nxt;
    if (idx == slot_idx_t'(RING_SLOTS - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + slot_idx_t'(1);
    end
    return nxt;
  endfunction

endpackage

// ----- design/msrf_ram.sv -----
// ---------------------------------------------------------------------------
// msrf_ram: generic single-port RAM
// One access per cycle, write when enabled, registered read data.
// ---------------------------------------------------------------------------
module msrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/msrf_ctrl.sv -----
// ---------------------------------------------------------------------------
// msrf_ctrl: controller for the message slot ring FIFO
// Input handshake and the idle / pop-stream sequencer.
// ---------------------------------------------------------------------------
module msrf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  msrf_pkg::dp_status_t status_i,
  output msrf_pkg::ctrl_cmd_t  cmd_o
);
  import msrf_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.pop_start) begin
          state_d = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (status_i.out_free && status_i.last_byte) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = status_i.out_free;
        cmd_o.wr_byte   = accept && (command_i == CMD_WRITE);
        cmd_o.pop_start = accept && (command_i == CMD_POP) && !status_i.empty;
        cmd_o.pop_empty = accept && (command_i == CMD_POP) && status_i.empty;
      end
      ST_STREAM: begin
        cmd_o.emit_byte = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && (state_q == ST_IDLE) && status_i.out_free;

endmodule

// ----- design/msrf_datapath.sv -----
// ---------------------------------------------------------------------------
// msrf_datapath: ring state, byte store, counters and output register
// Executes controller commands; reports empty / last byte / output space.
// ---------------------------------------------------------------------------
module msrf_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  msrf_pkg::ctrl_cmd_t  cmd_i,
  output msrf_pkg::dp_status_t status_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           out_status_o,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output logic [msrf_pkg::CNT_W-1:0] sent_messages_o,
  output logic [msrf_pkg::CNT_W-1:0] sent_bytes_o,
  output logic [msrf_pkg::CNT_W-1:0] received_messages_o,
  output logic [msrf_pkg::CNT_W-1:0] received_bytes_o,
  output logic [msrf_pkg::CNT_W-1:0] full_rejects_o
);
  import msrf_pkg::*;

  // ring control
  slot_idx_t rd_idx_q, rd_idx_d;
  slot_idx_t wr_idx_q, wr_idx_d;
  len_t      bip_q, bip_d;
  reject_e   reason_q, reason_d;
  len_t      slot_len_q [RING_SLOTS];
  logic [RING_SLOTS-1:0] slot_rdy_q;

  // pop stream
  slot_idx_t str_slot_q, str_slot_d;
  byte_idx_t str_idx_q, str_idx_d;
  len_t      str_len_q, str_len_d;

  // counters
  logic [CNT_W-1:0] sent_msg_q, sent_msg_d;
  logic [CNT_W-1:0] sent_byt_q, sent_byt_d;
  logic [CNT_W-1:0] rcv_msg_q, rcv_msg_d;
  logic [CNT_W-1:0] rcv_byt_q, rcv_byt_d;
  logic [CNT_W-1:0] full_q, full_d;

  // output register
  logic       out_valid_q, out_valid_d;
  status_e    out_stat_q, out_stat_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  // store port
  logic                ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [7:0]          ram_rdata;

  logic      commit;
  logic      store_byte;
  len_t      bip_inc;
  reject_e   reason_nxt;
  len_t      rd_len;

  assign rd_len  = slot_len_q[rd_idx_q];
  assign bip_inc = bip_q + len_t'(1);

  assign status_o.empty     = (rd_idx_q == wr_idx_q) || !slot_rdy_q[rd_idx_q]
                              || (rd_len == '0);
  assign status_o.last_byte = ((LEN_W)'(str_idx_q) + len_t'(1)) == str_len_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign store_byte = cmd_i.wr_byte && (reason_q == RJ_NONE) && (bip_q < len_t'(SLOT_BYTES));

  always_comb begin
    reason_nxt = reason_q;
    if (cmd_i.wr_byte && (reason_q == RJ_NONE) && !store_byte) begin
      reason_nxt = RJ_LONG;
    end
  end

  assign commit = cmd_i.wr_byte && last_i && (reason_nxt == RJ_NONE)
                  && (next_slot(wr_idx_q) != rd_idx_q);

  // ring control, counters, output register
  always_comb begin
    rd_idx_d    = rd_idx_q;
    wr_idx_d    = wr_idx_q;
    bip_d       = store_byte ? bip_inc : bip_q;
    reason_d    = reason_nxt;
    str_slot_d  = str_slot_q;
    str_idx_d   = str_idx_q;
    str_len_d   = str_len_q;
    sent_msg_d  = sent_msg_q;
    sent_byt_d  = sent_byt_q;
    rcv_msg_d   = rcv_msg_q;
    rcv_byt_d   = rcv_byt_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_stat_d  = out_stat_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (cmd_i.wr_byte && last_i) begin
      out_valid_d = 1'b1;
      out_byte_d  = '0;
      out_last_d  = 1'b1;
      bip_d       = '0;
      reason_d    = RJ_NONE;
      if (reason_nxt == RJ_LONG) begin
        out_stat_d = STAT_LONG;
      end else if (!commit) begin
        out_stat_d = STAT_FULL;
        full_d     = full_q + 64'd1;
      end else begin
        out_stat_d = STAT_ACCEPT;
        wr_idx_d   = next_slot(wr_idx_q);
        sent_msg_d = sent_msg_q + 64'd1;
        sent_byt_d = sent_byt_q + CNT_W'(store_byte ? bip_inc : bip_q);
      end
    end

    if (cmd_i.pop_empty) begin
      out_valid_d = 1'b1;
      out_stat_d  = STAT_EMPTY;
      out_byte_d  = '0;
      out_last_d  = 1'b1;
    end

    if (cmd_i.pop_start) begin
      str_slot_d = rd_idx_q;
      str_idx_d  = '0;
      str_len_d  = rd_len;
      rd_idx_d   = next_slot(rd_idx_q);
      rcv_msg_d  = rcv_msg_q + 64'd1;
      rcv_byt_d  = rcv_byt_q + CNT_W'(rd_len);
    end

    if (cmd_i.emit_byte) begin
      out_valid_d = 1'b1;
      out_stat_d  = STAT_BYTE;
      out_byte_d  = ram_rdata;
      out_last_d  = status_o.last_byte;
      str_idx_d   = str_idx_q + byte_idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      wr_idx_q    <= '0;
      bip_q       <= '0;
      reason_q    <= RJ_NONE;
      slot_rdy_q  <= '0;
      sent_msg_q  <= '0;
      sent_byt_q  <= '0;
      rcv_msg_q   <= '0;
      rcv_byt_q   <= '0;
      full_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < RING_SLOTS; i++) begin
        slot_len_q[i] <= '0;
      end
    end else begin
      rd_idx_q    <= rd_idx_d;
      wr_idx_q    <= wr_idx_d;
      bip_q       <= bip_d;
      reason_q    <= reason_d;
      sent_msg_q  <= sent_msg_d;
      sent_byt_q  <= sent_byt_d;
      rcv_msg_q   <= rcv_msg_d;
      rcv_byt_q   <= rcv_byt_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        slot_len_q[wr_idx_q] <= store_byte ? bip_inc : bip_q;
        slot_rdy_q[wr_idx_q] <= 1'b1;
      end
      if (cmd_i.pop_start) begin
        slot_rdy_q[rd_idx_q] <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    str_slot_q <= str_slot_d;
    str_idx_q  <= str_idx_d;
    str_len_q  <= str_len_d;
    out_stat_q <= out_stat_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  // store address: write slot, then next stream byte, then first byte of
  // a new pop; otherwise re-read the current byte so a stall holds it
  always_comb begin
    ram_we = store_byte;
    priority if (cmd_i.wr_byte) begin
      ram_addr = {wr_idx_q, bip_q[BYTE_IDX_W-1:0]};
    end else if (cmd_i.emit_byte) begin
      ram_addr = {str_slot_q, str_idx_q + byte_idx_t'(1)};
    end else if (cmd_i.pop_start) begin
      ram_addr = {rd_idx_q, byte_idx_t'(0)};
    end else begin
      ram_addr = {str_slot_q, str_idx_q};
    end
  end

  msrf_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(data_byte_i),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_stat_q;
  assign out_byte_o          = out_byte_q;
  assign out_last_o          = out_last_q;
  assign sent_messages_o     = sent_msg_q;
  assign sent_bytes_o        = sent_byt_q;
  assign received_messages_o = rcv_msg_q;
  assign received_bytes_o    = rcv_byt_q;
  assign full_rejects_o      = full_q;

endmodule

// ----- design/message_slot_ring_fifo.sv -----
// ---------------------------------------------------------------------------
// message_slot_ring_fifo: single-ring message FIFO with fixed-size slots
// Byte-wise message writes, whole-message pops, wrapping traffic counters.
// ---------------------------------------------------------------------------
// A ring of RING_SLOTS slots, each holding one message of up to SLOT_BYTES
// bytes; one slot always stays empty, so at most RING_SLOTS-1 messages wait.
// Write items (command 0) carry one byte each and are taken one per cycle
// while the output register has room; only the item with last set produces
// a result: accepted, rejected full or rejected too long. A pop item
// (command 1) produces one result per stored byte (status 3, out_last on the
// final byte), or a single empty result. A pop of a message first starts
// the registered read of the single-port byte store, then streams one byte
// per cycle while the output is taken; no item is accepted meanwhile. The
// five 64-bit counters are driven straight from their registers and carry
// the totals after the input that caused the current result.
// ---------------------------------------------------------------------------
module message_slot_ring_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic [63:0] sent_messages_o,
  output logic [63:0] sent_bytes_o,
  output logic [63:0] received_messages_o,
  output logic [63:0] received_bytes_o,
  output logic [63:0] full_rejects_o
);
  import msrf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // sequencer: handshake and pop streaming
  msrf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .command_i (command_i),
    .status_i  (dp_status),
    .cmd_o     (cmd)
  );

  // ring pointers, byte store, counters, output register
  msrf_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (dp_status),
    .data_byte_i        (data_byte_i),
    .last_i             (last_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_status_o       (status_o),
    .out_byte_o         (out_byte_o),
    .out_last_o         (out_last_o),
    .sent_messages_o    (sent_messages_o),
    .sent_bytes_o       (sent_bytes_o),
    .received_messages_o(received_messages_o),
    .received_bytes_o   (received_bytes_o),
    .full_rejects_o     (full_rejects_o)
  );

endmodule
